// ===== rtl/adcss_pkg.sv =====
package adcss_pkg;

    // field and datapath widths
    localparam int CODE_W      = 10;
    localparam int FS_W        = 24;
    localparam int PROD_W      = CODE_W + FS_W;
    localparam int M_W         = 24;
    localparam int RECIP_W     = 25;
    localparam int MPROD_W     = M_W + RECIP_W;
    localparam int SHOWN_W     = 14;
    localparam int QUOT_W      = 11;
    localparam int SEG_W       = 7;
    localparam int POS_W       = 2;
    localparam int DIGIT_W     = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // scaled value m in thousandths is product divided by 1024
    localparam int SCALE_SHIFT = 10;

    // autorange thresholds, thousandths
    localparam logic [M_W-1:0] LIM_CENTI = 24'd10000;
    localparam logic [M_W-1:0] LIM_DECI  = 24'd100000;
    localparam logic [M_W-1:0] LIM_UNIT  = 24'd1000000;
    localparam logic [M_W-1:0] LIM_OVER  = 24'd10000000;

    // exact reciprocals for m below ten million: q = (m * R) >> S
    localparam logic [RECIP_W-1:0] RECIP_10   = 25'd13421773;
    localparam logic [RECIP_W-1:0] RECIP_100  = 25'd10737419;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd17179870;
    localparam int SHIFT_10   = 27;
    localparam int SHIFT_100  = 30;
    localparam int SHIFT_1000 = 34;

    // digit extraction, exact divide by ten for values under 2**18
    localparam int DIV10_W = 16;
    localparam logic [DIV10_W-1:0] DIV10_RECIP = 16'd52429;
    localparam int DIV10_SHIFT = 19;
    localparam int DIV10_PROD_W = SHOWN_W + DIV10_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [POS_W-1:0] POS_LAST = 2'd3;

    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
    localparam logic [SEG_W-1:0] SEG_E     = 7'h79;

    typedef enum logic [2:0] {
        RNG_MILLI,
        RNG_CENTI,
        RNG_DECI,
        RNG_UNIT,
        RNG_OVER
    } range_t;

    typedef struct packed {
        logic [SHOWN_W-1:0] shown;
        logic               over;
        logic               point_en;
        logic [POS_W-1:0]   point_pos;
    } disp_item_t;

    function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7C;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/adcss_front.sv =====
module adcss_front
    import adcss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CODE_W-1:0]  in_code,
    input  logic [FS_W-1:0]    full_scale,
    output logic               push,
    output disp_item_t         push_item,
    input  logic               q_full
);

    logic               v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [M_W-1:0]     m_reg;
    range_t             rng2_reg, rng3_reg;
    logic [MPROD_W-1:0] mprod_reg;
    logic [SHOWN_W-1:0] mlo_reg;

    logic               adv;
    logic [M_W-1:0]     m_w;
    range_t             rng_w;
    logic [RECIP_W-1:0] recip_w;

    // whole pipe moves unless the last stage is held by a full queue
    assign adv      = !v3_reg || !q_full;
    assign in_ready = adv;
    assign push     = v3_reg && !q_full;

    assign m_w = p_reg[SCALE_SHIFT +: M_W];

    always_comb begin
        if (m_w >= LIM_OVER)       rng_w = RNG_OVER;
        else if (m_w >= LIM_UNIT)  rng_w = RNG_UNIT;
        else if (m_w >= LIM_DECI)  rng_w = RNG_DECI;
        else if (m_w >= LIM_CENTI) rng_w = RNG_CENTI;
        else                       rng_w = RNG_MILLI;
    end

    always_comb begin
        case (rng2_reg)
            RNG_CENTI: recip_w = RECIP_10;
            RNG_DECI:  recip_w = RECIP_100;
            default:   recip_w = RECIP_1000;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg     <= PROD_W'(in_code) * PROD_W'(full_scale);
            m_reg     <= m_w;
            rng2_reg  <= rng_w;
            mprod_reg <= MPROD_W'(m_reg) * MPROD_W'(recip_w);
            mlo_reg   <= m_reg[SHOWN_W-1:0];
            rng3_reg  <= rng2_reg;
        end
    end

    always_comb begin
        push_item.over      = 1'b0;
        push_item.point_en  = 1'b1;
        push_item.point_pos = 2'd3;
        push_item.shown     = mlo_reg;
        case (rng3_reg)
            RNG_MILLI: begin
                push_item.point_pos = 2'd3;
            end
            RNG_CENTI: begin
                push_item.shown     = mprod_reg[SHIFT_10 +: SHOWN_W];
                push_item.point_pos = 2'd2;
            end
            RNG_DECI: begin
                push_item.shown     = mprod_reg[SHIFT_100 +: SHOWN_W];
                push_item.point_pos = 2'd1;
            end
            RNG_UNIT: begin
                push_item.shown    = mprod_reg[SHIFT_1000 +: SHOWN_W];
                push_item.point_en = 1'b0;
            end
            default: begin
                push_item.over     = 1'b1;
                push_item.point_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/adcss_queue.sv =====
module adcss_queue
    import adcss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  disp_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output disp_item_t pop_item
);

    disp_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, rd_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_item;
    end

endmodule

// ===== rtl/adcss_back.sv =====
module adcss_back
    import adcss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  disp_item_t           q_item,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic                    busy_reg;
    logic [SHOWN_W-1:0]      x_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    over_reg, pen_reg;
    logic [POS_W-1:0]        ppos_reg;

    logic                    out_v_reg;
    logic [POS_W-1:0]        out_pos_reg;
    logic [SEG_W-1:0]        out_seg_reg;
    logic                    out_dp_reg, out_last_reg;

    logic                    out_free, emit, last_emit;
    logic [DIV10_PROD_W-1:0] dprod;
    logic [QUOT_W-1:0]       quot;
    logic [SHOWN_W-1:0]      rem;
    logic [SEG_W-1:0]        seg_w;

    assign out_free  = !out_v_reg || m_tready;
    assign emit      = busy_reg && out_free;
    assign last_emit = emit && (pos_reg == POS_LAST);
    assign pop       = q_valid && (!busy_reg || last_emit);

    // peel off the lowest decimal digit
    assign dprod = DIV10_PROD_W'(x_reg) * DIV10_PROD_W'(DIV10_RECIP);
    assign quot  = dprod[DIV10_SHIFT +: QUOT_W];
    assign rem   = x_reg - ((SHOWN_W'(quot) << 3) + (SHOWN_W'(quot) << 1));

    always_comb begin
        if (over_reg) seg_w = (pos_reg == '0) ? SEG_E : SEG_BLANK;
        else          seg_w = seg_of_digit(rem[DIGIT_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (pop)            busy_reg <= 1'b1;
            else if (last_emit) busy_reg <= 1'b0;
            if (emit)           out_v_reg <= 1'b1;
            else if (m_tready)  out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg    <= q_item.shown;
            pos_reg  <= '0;
            over_reg <= q_item.over;
            pen_reg  <= q_item.point_en;
            ppos_reg <= q_item.point_pos;
        end else if (emit) begin
            x_reg   <= SHOWN_W'(quot);
            pos_reg <= pos_reg + 1'b1;
        end
        if (emit) begin
            out_pos_reg  <= pos_reg;
            out_seg_reg  <= seg_w;
            out_dp_reg   <= pen_reg && (ppos_reg == pos_reg);
            out_last_reg <= (pos_reg == POS_LAST);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W-POS_W-SEG_W-1){1'b0}}, out_dp_reg, out_seg_reg, out_pos_reg};

endmodule

// ===== rtl/adc_to_seven_segment_readout.sv =====
// seven-segment voltmeter readout: each 10-bit converter code on the s_ side is
// scaled to thousandths as floor(code * full_scale / 1024), autoranged to four
// digits (point on digit 3, 2, 1 or none; E on digit 0 at ten thousand units or
// more) and sent as four m_ transfers, digit 0 first, tlast on digit 3. leading
// zeros are shown. the digit unit emits one digit per cycle while m_tready
// allows; the front pipe (3 stages: scale multiply, range pick, reciprocal
// divide) accepts one sample per cycle into a 4-deep queue while the queue
// has room. the full-scale register resets to 5000 and is written by
// cfg_wr_en; the user must write it only while idle, as the block does not enforce it.
module adc_to_seven_segment_readout
    import adcss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write, full scale in thousandths
    input  logic                 cfg_wr_en,
    input  logic [FS_W-1:0]      cfg_wr_data,
    // sample channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] adc_code
    // digit channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] digit_position, [8:2] segments,
                                            // [9] decimal_point
    output logic                 m_tlast    // last_digit
);

    logic [FS_W-1:0] fs_reg;

    logic       push, q_full, pop, q_valid;
    disp_item_t push_item, q_item;

    // full-scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg <= FS_W'(5000);
        end else if (cfg_wr_en) begin
            fs_reg <= cfg_wr_data;
        end
    end

    // front: scale, range and divide down to a four-digit value
    adcss_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_code    (s_tdata[CODE_W-1:0]),
        .full_scale (fs_reg),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    // queue lets the front keep taking samples while digits drain
    adcss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    // back: one digit per transfer, registered output
    adcss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== verif/tb_adc_to_seven_segment_readout.sv =====
`timescale 1ns / 1ps

module tb_adc_to_seven_segment_readout;
    import adcss_pkg::*;

    localparam int STALL_LIMIT  = 1000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 8;    // front pipe plus queue, a little over the latency
    localparam int IDLE_PCT     = 36;
    localparam int MAX_PRINTS   = 40;

    // own segment table, bit0 = a .. bit6 = g
    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [SEG_W-1:0] seg;
        logic             point;
        logic             last;
    } digit_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [FS_W-1:0]      cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [9:0] adc_code
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // [1:0] digit_position, [8:2] segments,
                                              // [9] decimal_point
    logic                 m_tlast;            // last_digit

    // predictor state: the full-scale register as the block should hold it
    logic [FS_W-1:0] full_scale = 24'd5000;
    digit_t          pending_digits[$];
    int              error_count = 0;
    int              quiet_cycles = 0;
    bit              steady_flow = 1'b0;      // when set neither side idles

    adc_to_seven_segment_readout dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #1 aclk = ~aclk;

    // result side backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // scale, autorange and split into four digits, least significant first
    function automatic void predict_readout(input logic [CODE_W-1:0] code);
        logic [PROD_W-1:0] product;
        logic [M_W-1:0]    milli;
        logic [M_W-1:0]    shown;
        range_t            rng;
        int                point_at;
        digit_t            d;
        product = PROD_W'(code) * PROD_W'(full_scale);
        milli   = M_W'(product >> SCALE_SHIFT);
        if (milli >= 24'd10000000)     rng = RNG_OVER;
        else if (milli >= 24'd1000000) rng = RNG_UNIT;
        else if (milli >= 24'd100000)  rng = RNG_DECI;
        else if (milli >= 24'd10000)   rng = RNG_CENTI;
        else                           rng = RNG_MILLI;
        case (rng)
            RNG_UNIT: begin
                shown = milli / 1000;
                point_at = -1;
            end
            RNG_DECI: begin
                shown = milli / 100;
                point_at = 1;
            end
            RNG_CENTI: begin
                shown = milli / 10;
                point_at = 2;
            end
            RNG_MILLI: begin
                shown = milli;
                point_at = 3;
            end
            default: begin
                shown = '0;
                point_at = -1;
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            d.pos   = POS_W'(k);
            d.point = (point_at == k);
            d.last  = (k == 3);
            if (rng == RNG_OVER)
                d.seg = (k == 0) ? SEG_E : SEG_BLANK;
            else
                d.seg = DIGIT_SEGS[shown % 10];
            shown = shown / 10;
            pending_digits.push_back(d);
        end
    endfunction

    // one sample transfer, with random gaps before it
    task automatic send_sample(input logic [CODE_W-1:0] code);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(code);
        do @(posedge aclk); while (!s_tready);
        predict_readout(code);
    endtask

    // sender holds off until every expected digit is out, then lets the pipe settle
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_full_scale(input logic [FS_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        full_scale   = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // default register after reset, alternating code bits
    task automatic test_default_scale();
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'h155);
        send_sample(10'h2AA);
    endtask

    // each scale puts code 1000 exactly on a range boundary and 999 just below it
    task automatic test_range_edges();
        logic [FS_W-1:0] edge_scales [4] = '{24'd10240, 24'd102400, 24'd1024000, 24'd10240000};
        foreach (edge_scales[i]) begin
            write_full_scale(edge_scales[i]);
            send_sample(10'd999);
            send_sample(10'd1000);
        end
        send_sample(10'd1023);   // overrange, E on digit 0
    endtask

    // zero full scale reads 0.000, all-ones full scale overranges at the top
    task automatic test_scale_extremes();
        write_full_scale('0);
        send_sample(10'd1023);
        send_sample(10'h2AA);
        write_full_scale('1);
        send_sample(10'd1023);
        send_sample(10'd1);
        send_sample(10'h200);
    endtask

    function automatic logic [FS_W-1:0] random_full_scale();
        case ($urandom_range(0, 6))
            0: return FS_W'($urandom_range(1, 9999));
            1: return FS_W'($urandom_range(10000, 99999));
            2: return FS_W'($urandom_range(100000, 999999));
            3: return FS_W'($urandom_range(1000000, 9999999));
            4: return FS_W'($urandom_range(10000000, 16777215));
            5: return '1;
            default: return FS_W'($urandom);
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 15))
            0: return 10'd0;
            1: return 10'd1023;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    // random register settings, several phases
    task automatic test_random_samples(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            write_full_scale(random_full_scale());
            repeat (per_phase) send_sample(random_code());
        end
    endtask

    // long stretch with both sides always ready
    task automatic test_back_to_back();
        steady_flow = 1'b1;
        write_full_scale(FS_W'($urandom_range(1000000, 16777215)));
        repeat (50) send_sample(random_code());
        steady_flow = 1'b0;
    endtask

    // sender pauses mid-run until the result side has caught up
    task automatic test_sender_pause();
        repeat (10) send_sample(random_code());
        drain_results();
        repeat (10) send_sample(random_code());
    endtask

    // every digit transfer is checked against the oldest prediction
    always @(posedge aclk) begin
        digit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("unexpected digit, position", m_tdata[1:0], -1);
            end else begin
                want = pending_digits.pop_front();
                if (m_tdata[1:0] !== want.pos)
                    report_mismatch("digit_position", m_tdata[1:0], want.pos);
                if (m_tdata[8:2] !== want.seg)
                    report_mismatch("segments", m_tdata[8:2], want.seg);
                if (m_tdata[9] !== want.point)
                    report_mismatch("decimal_point", m_tdata[9], want.point);
                if (m_tlast !== want.last)
                    report_mismatch("last_digit", m_tlast, want.last);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout, %0d digits still expected", pending_digits.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_scale();
        test_range_edges();
        test_scale_extremes();
        test_random_samples(4, 30);
        test_back_to_back();
        test_sender_pause();
        test_random_samples(3, 25);

        // let everything come out, then watch a while for stray digits
        drain_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
